// ===== src/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB conversion package
// Transfer types, hue sector codes, constants and the small helpers that the
// converter's pipeline shares.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   // Width of a hue sector in degrees and the full-scale channel level.
   localparam int unsigned HUE_SECTOR = 60;
   localparam int unsigned FULL_LEVEL = 255;

   // Hue sector boundaries in degrees.
   localparam logic [8:0] HUE_60  = 9'd60;
   localparam logic [8:0] HUE_120 = 9'd120;
   localparam logic [8:0] HUE_180 = 9'd180;
   localparam logic [8:0] HUE_240 = 9'd240;
   localparam logic [8:0] HUE_300 = 9'd300;
   localparam logic [8:0] HUE_360 = 9'd360;
   localparam logic [8:0] HUE_480 = 9'd480;

   // Reciprocal of sixty: floor(2^16 / 60). The estimate it gives is the
   // true quotient or one below it for every dividend of 14 bits.
   localparam int unsigned RECIP_60    = 1092;
   localparam int unsigned RECIP_SHIFT = 16;

   // Width of the scaled secondary level before the division by sixty.
   localparam int unsigned LEVEL_Q_WIDTH = 14;

   // One input transfer: an HSV pixel.
   typedef struct packed {
      logic [8:0] hue_degrees;
      logic [8:0] saturation;
      logic [8:0] brightness;
   } hsv2rgb_req_type;

   // One result transfer: an RGB triple.
   typedef struct packed {
      logic [7:0] red_level;
      logic [7:0] green_level;
      logic [7:0] blue_level;
   } hsv2rgb_rsp_type;

   // Hue sector, which decides where chroma, secondary and zero go.
   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW,
      SECTOR_YELLOW_GREEN,
      SECTOR_GREEN_CYAN,
      SECTOR_CYAN_BLUE,
      SECTOR_BLUE_MAGENTA,
      SECTOR_MAGENTA_RED
   } hsv2rgb_sector_type;

   // Clamp a nine-bit level to the eight-bit channel range.
   function automatic logic [7:0] sat_level(input logic [8:0] level);
      logic [7:0] result;
      if (level[8]) begin
         result = 8'(FULL_LEVEL);
      end else begin
         result = level[7:0];
      end
      return result;
   endfunction

endpackage

// ===== src/hsv_to_rgb_converter_unit.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter unit
// Six-stage pipeline that turns one HSV pixel into an eight-bit RGB triple.
// ----------------------------------------------------------------------------
// The unit takes one pixel in every clock while req_stall is low and
// returns its RGB triple, one register stage per step: sector decode, the chroma
// product S*V, the secondary product C*k, the scaled channel sums, the
// reciprocal estimate of the division by sixty and its correction with the
// channel assignment. Saturation and value are fractions where
// 2^FRACTION_BITS means 1.0, and larger codes count as 1.0. Each channel is
// floor((channel + m) * 255) of the exact rational result. The pipeline
// holds under a stall and closes bubbles, so a full rate stream loses nothing.
module hsv_to_rgb_converter_unit
   import hsv2rgb_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  hsv2rgb_req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output hsv2rgb_rsp_type rsp_data
);

   localparam int unsigned NUM_STAGES = 6;
   // Fraction width including the code for 1.0.
   localparam int unsigned FW  = FRACTION_BITS + 1;
   // Width used to compare a nine-bit code against 1.0.
   localparam int unsigned CW  = (FW > 9) ? FW : 9;
   // Width of S*V and of the offset term, both at most 2^(2*FRACTION_BITS).
   localparam int unsigned SVW = 2 * FRACTION_BITS + 1;
   // Width of C*k; the secondary numerator has its own width NXW.
   localparam int unsigned PW  = SVW + 6;
   localparam int unsigned NXW = 2 * FRACTION_BITS + 6;
   localparam int unsigned QW  = LEVEL_Q_WIDTH;
   localparam int unsigned EW  = QW + 11;
   localparam logic [CW-1:0] ONE = CW'(1) << FRACTION_BITS;

   // Pipeline flow control.
   logic [NUM_STAGES:1] vld_ff;
   logic [NUM_STAGES:1] vld_in;
   logic [NUM_STAGES:0] en;

   // Stage registers.
   logic [FW-1:0]      s1_sat_ff, s1_sat_in;
   logic [FW-1:0]      s1_val_ff, s1_val_in;
   logic [5:0]         s1_k_ff, s1_k_in;
   hsv2rgb_sector_type s1_sector_ff, s1_sector_in;

   logic [SVW-1:0]     s2_sv_ff, s2_sv_in;
   logic [FW-1:0]      s2_val_ff;
   logic [5:0]         s2_k_ff;
   hsv2rgb_sector_type s2_sector_ff;

   logic [PW-1:0]      s3_prod_ff, s3_prod_in;
   logic [SVW-1:0]     s3_mpart_ff, s3_mpart_in;
   logic [FW-1:0]      s3_val_ff;
   hsv2rgb_sector_type s3_sector_ff;

   logic [QW-1:0]      s4_q_ff, s4_q_in;
   logic [7:0]         s4_c_ff, s4_c_in;
   logic [7:0]         s4_z_ff, s4_z_in;
   hsv2rgb_sector_type s4_sector_ff;

   logic [8:0]         s5_est_ff, s5_est_in;
   logic [QW-1:0]      s5_q_ff;
   logic [7:0]         s5_c_ff;
   logic [7:0]         s5_z_ff;
   hsv2rgb_sector_type s5_sector_ff;

   hsv2rgb_rsp_type    rsp_data_ff, rsp_data_in;

   // A stage loads when it is empty or the stage after it moves on.
   always_comb begin
      en[NUM_STAGES] = !vld_ff[NUM_STAGES] || !rsp_stall;
      for (int i = NUM_STAGES - 1; i >= 0; i--) begin
         if (i == 0) begin
            en[i] = en[1];
         end else begin
            en[i] = !vld_ff[i] || en[i+1];
         end
      end
      vld_in[1] = req_valid;
      for (int i = 2; i <= NUM_STAGES; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = vld_ff[NUM_STAGES];
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 1; i <= NUM_STAGES; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // Stage one: clamp the fractions to 1.0 and decode the hue sector and the
   // secondary weight k, which is the distance of the hue from the nearest
   // multiple of 120 degrees, folded about 60.
   always_comb begin
      logic [CW-1:0] sat_wide;
      logic [CW-1:0] val_wide;
      logic [8:0]    hue;
      logic [8:0]    rem;
      sat_wide = CW'(req_data.saturation);
      val_wide = CW'(req_data.brightness);
      hue      = req_data.hue_degrees;
      s1_sat_in = (sat_wide > ONE) ? FW'(ONE) : FW'(sat_wide);
      s1_val_in = (val_wide > ONE) ? FW'(ONE) : FW'(val_wide);

      priority if (hue >= HUE_480) begin
         rem = hue - HUE_480;
      end else if (hue >= HUE_360) begin
         rem = hue - HUE_360;
      end else if (hue >= HUE_240) begin
         rem = hue - HUE_240;
      end else if (hue >= HUE_120) begin
         rem = hue - HUE_120;
      end else begin
         rem = hue;
      end

      if (rem >= HUE_60) begin
         s1_k_in = 6'(HUE_120 - rem);
      end else begin
         s1_k_in = rem[5:0];
      end

      // Hue of 300 and above, including codes past 359, take the last sector.
      priority if (hue < HUE_60) begin
         s1_sector_in = SECTOR_RED_YELLOW;
      end else if (hue < HUE_120) begin
         s1_sector_in = SECTOR_YELLOW_GREEN;
      end else if (hue < HUE_180) begin
         s1_sector_in = SECTOR_GREEN_CYAN;
      end else if (hue < HUE_240) begin
         s1_sector_in = SECTOR_CYAN_BLUE;
      end else if (hue < HUE_300) begin
         s1_sector_in = SECTOR_BLUE_MAGENTA;
      end else begin
         s1_sector_in = SECTOR_MAGENTA_RED;
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_sat_ff    <= s1_sat_in;
         s1_val_ff    <= s1_val_in;
         s1_k_ff      <= s1_k_in;
         s1_sector_ff <= s1_sector_in;
      end
   end

   // Stage two: chroma scaled by 2^(2*FRACTION_BITS).
   assign s2_sv_in = SVW'(s1_sat_ff) * SVW'(s1_val_ff);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_sv_ff     <= s2_sv_in;
         s2_val_ff    <= s1_val_ff;
         s2_k_ff      <= s1_k_ff;
         s2_sector_ff <= s1_sector_ff;
      end
   end

   // Stage three: secondary product C*k and the offset m, both over the
   // same scale as the chroma.
   assign s3_prod_in  = PW'(s2_sv_ff) * PW'(s2_k_ff);
   assign s3_mpart_in = (SVW'(s2_val_ff) << FRACTION_BITS) - s2_sv_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_prod_ff   <= s3_prod_in;
         s3_mpart_ff  <= s3_mpart_in;
         s3_val_ff    <= s2_val_ff;
         s3_sector_ff <= s2_sector_ff;
      end
   end

   // Stage four: scale the three channel sums by 255. Chroma plus offset
   // reduces to V*255, and offset alone to m*255; both divide by a power of
   // two. The secondary sum still carries a factor of sixty.
   always_comb begin
      logic [NXW-1:0]          nx;
      logic [NXW+7:0]          nx_scaled;
      logic [FW+7:0]           c_scaled;
      logic [SVW+7:0]          z_scaled;
      nx        = NXW'(s3_prod_ff) + NXW'(s3_mpart_ff) * NXW'(HUE_SECTOR);
      nx_scaled = (NXW+8)'(nx) * (NXW+8)'(FULL_LEVEL);
      c_scaled  = (FW+8)'(s3_val_ff) * (FW+8)'(FULL_LEVEL);
      z_scaled  = (SVW+8)'(s3_mpart_ff) * (SVW+8)'(FULL_LEVEL);
      s4_q_in   = nx_scaled[2*FRACTION_BITS+QW-1:2*FRACTION_BITS];
      s4_c_in   = sat_level(c_scaled[FRACTION_BITS+8:FRACTION_BITS]);
      s4_z_in   = sat_level(z_scaled[2*FRACTION_BITS+8:2*FRACTION_BITS]);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_q_ff      <= s4_q_in;
         s4_c_ff      <= s4_c_in;
         s4_z_ff      <= s4_z_in;
         s4_sector_ff <= s3_sector_ff;
      end
   end

   // Stage five: quotient estimate of the division by sixty.
   always_comb begin
      logic [EW-1:0] est_wide;
      est_wide  = EW'(s4_q_ff) * EW'(RECIP_60);
      s5_est_in = est_wide[RECIP_SHIFT+8:RECIP_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_est_ff    <= s5_est_in;
         s5_q_ff      <= s4_q_ff;
         s5_c_ff      <= s4_c_ff;
         s5_z_ff      <= s4_z_ff;
         s5_sector_ff <= s4_sector_ff;
      end
   end

   // Stage six: correct the estimate by one where the remainder reaches
   // sixty, then route chroma, secondary and zero levels by sector.
   always_comb begin
      logic [QW-1:0] rem;
      logic [8:0]    x_full;
      logic [7:0]    x_lvl;
      rem = s5_q_ff - QW'(s5_est_ff) * QW'(HUE_SECTOR);
      if (rem >= QW'(HUE_SECTOR)) begin
         x_full = s5_est_ff + 9'd1;
      end else begin
         x_full = s5_est_ff;
      end
      x_lvl = sat_level(x_full);

      unique case (s5_sector_ff)
         SECTOR_RED_YELLOW: begin
            rsp_data_in = '{red_level: s5_c_ff, green_level: x_lvl, blue_level: s5_z_ff};
         end
         SECTOR_YELLOW_GREEN: begin
            rsp_data_in = '{red_level: x_lvl, green_level: s5_c_ff, blue_level: s5_z_ff};
         end
         SECTOR_GREEN_CYAN: begin
            rsp_data_in = '{red_level: s5_z_ff, green_level: s5_c_ff, blue_level: x_lvl};
         end
         SECTOR_CYAN_BLUE: begin
            rsp_data_in = '{red_level: s5_z_ff, green_level: x_lvl, blue_level: s5_c_ff};
         end
         SECTOR_BLUE_MAGENTA: begin
            rsp_data_in = '{red_level: x_lvl, green_level: s5_z_ff, blue_level: s5_c_ff};
         end
         default: begin
            rsp_data_in = '{red_level: s5_c_ff, green_level: s5_z_ff, blue_level: x_lvl};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
